### hdl/assert_macros.svh
// assertion macros shared by the signature search modules
// no dependencies; define SYNTH to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every clock edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/wsig_pkg.sv
// shared types, codes and hex helpers for the signature search
// used by wsig_cell, wsig_ctrl and the top level
package wsig_pkg;

    // field widths fixed by the interface
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 8;
    localparam int RES_OFF_W = 32;
    // cell index width, covers the largest supported pattern
    localparam int IDX_W    = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
    localparam logic [OP_W-1:0] OP_MEMORY  = 2'd1;
    localparam logic [OP_W-1:0] OP_END     = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LONE_DIGIT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MATCH      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NO_PATTERN = 3'd7;

    // special pattern characters
    localparam logic [DATA_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [DATA_W-1:0] CHAR_WILD  = 8'h3F;
    localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;

    // ascii offsets for digit and letter values
    localparam logic [DATA_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [DATA_W-1:0] ALPHA_BASE = 8'd55;

    // command from the controller to every cell
    typedef struct packed {
        logic              clr_pat;
        logic              clr_scan;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic              wr_wild;
        logic              shift;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

    function automatic logic [DATA_W-1:0] to_upper(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic hex_ok(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] u;
        u = to_upper(c);
        return (u >= 8'h30 && u <= 8'h39) || (u >= 8'h41 && u <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [DATA_W-1:0] c);
        logic [DATA_W-1:0] u;
        logic [DATA_W-1:0] d;
        u = to_upper(c);
        if (u >= 8'h30 && u <= 8'h39)
        begin
            d = u - DIGIT_BASE;
        end
        else
        begin
            d = u - ALPHA_BASE;
        end
        return d[3:0];
    endfunction

endpackage

### hdl/wsig_cell.sv
// one pattern entry of the shift-and chain: byte, wildcard mark, match bit
// depends on wsig_pkg for the command struct
module wsig_cell
    import wsig_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      prev_match,
    input  logic      next_valid,
    output logic      valid,
    output logic      match,
    output logic      hit
);

    logic              valid_reg;
    logic              valid_next;
    logic              wild_reg;
    logic [DATA_W-1:0] byte_reg;
    logic              match_reg;
    logic              match_next;
    logic              sel;
    logic              match_now;

    assign sel = cmd.wr_en && (cmd.wr_idx == IDX_W'(INDEX));

    // this entry extends a partial match ending one byte earlier
    assign match_now = prev_match && valid_reg && (wild_reg || (byte_reg == cmd.data));

    // last filled entry reports a complete match
    assign hit = match_now && !next_valid;

    // entry occupancy, write wins over a same-cycle clear
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clr_pat)
        begin
            valid_next = 1'b0;
        end
        if (sel)
        begin
            valid_next = 1'b1;
        end
    end

    // match bit update
    always_comb
    begin
        match_next = match_reg;
        if (cmd.clr_scan)
        begin
            match_next = 1'b0;
        end
        else if (cmd.shift)
        begin
            match_next = match_now;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            wild_reg <= cmd.wr_wild;
            byte_reg <= cmd.data;
        end
    end

    assign valid = valid_reg;
    assign match = match_reg;

endmodule

### hdl/wsig_ctrl.sv
// signature parser, scan sequencing and result register
// depends on wsig_pkg and assert_macros.svh; drives the cell chain
`include "assert_macros.svh"

module wsig_ctrl
    import wsig_pkg::*;
#(
    parameter int MAX_PATTERN = 128,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [DATA_W-1:0]    value,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [RES_OFF_W-1:0] match_offset,
    input  logic                 hit,
    output cell_cmd_t            cmd
);

    localparam int LEN_W = $clog2(MAX_PATTERN);

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_SCAN,
        PH_REJECT,
        PH_FOUND
    } phase_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [DATA_W-1:0]    pend_reg;
    logic [DATA_W-1:0]    pend_next;
    logic                 dpend_reg;
    logic                 dpend_next;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [OFFSET_BITS-1:0] found_reg;
    logic [OFFSET_BITS-1:0] found_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [RES_OFF_W-1:0] match_offset_reg;
    logic [RES_OFF_W-1:0] match_offset_next;

    logic                 fire;
    logic [OFFSET_BITS-1:0] off_val;
    logic [OFFSET_BITS+RES_OFF_W-1:0] off_ext;
    logic [LEN_W-1:0]     len_m1;
    logic [OFFSET_BITS-1:0] hit_offset;
    logic [DATA_W-1:0]    hex_byte;
    logic [LEN_W-1:0]     len_eff;
    logic                 dpend_eff;
    logic                 do_reject;
    logic [STATUS_W-1:0]  rej_code;
    logic                 do_append;
    logic                 app_wild;
    logic [DATA_W-1:0]    app_byte;

    // output register frees up whenever its transaction is taken
    assign item_ready = !result_valid_reg || result_ready;
    assign fire       = item_valid && item_ready;

    assign len_m1     = len_reg - LEN_W'(1);
    assign hit_offset = offset_reg - OFFSET_BITS'(len_m1);
    assign hex_byte   = {hex_val(pend_reg), hex_val(value)};

    // parse and scan decisions for the accepted transaction
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        pend_next   = pend_reg;
        dpend_next  = dpend_reg;
        offset_next = offset_reg;
        found_next  = found_reg;
        status_next = ST_OK;
        off_val     = '0;
        cmd         = '0;
        cmd.data    = value;
        len_eff     = len_reg;
        dpend_eff   = dpend_reg;
        do_reject   = 1'b0;
        rej_code    = ST_OK;
        do_append   = 1'b0;
        app_wild    = 1'b0;
        app_byte    = value;

        if (fire)
        begin
            case (operation)
                OP_PATTERN:
                begin
                    if (phase_reg == PH_REJECT)
                    begin
                        // ignore characters until the terminating nul
                        if (value == CHAR_NUL)
                        begin
                            cmd.clr_pat  = 1'b1;
                            cmd.clr_scan = 1'b1;
                            len_next     = '0;
                            pend_next    = '0;
                            dpend_next   = 1'b0;
                            offset_next  = '0;
                            found_next   = '0;
                            phase_next   = PH_COLLECT;
                        end
                    end
                    else
                    begin
                        // a character after a finished pattern starts a new one
                        if (phase_reg != PH_COLLECT)
                        begin
                            cmd.clr_pat  = 1'b1;
                            cmd.clr_scan = 1'b1;
                            len_next     = '0;
                            pend_next    = '0;
                            dpend_next   = 1'b0;
                            offset_next  = '0;
                            found_next   = '0;
                            phase_next   = PH_COLLECT;
                            len_eff      = '0;
                            dpend_eff    = 1'b0;
                        end
                        if (value inside {CHAR_NUL, CHAR_WILD, CHAR_SPACE})
                        begin
                            if (dpend_eff)
                            begin
                                do_reject = 1'b1;
                                rej_code  = ST_LONE_DIGIT;
                            end
                            else if (value == CHAR_SPACE)
                            begin
                                status_next = ST_OK;
                            end
                            else if (value == CHAR_WILD)
                            begin
                                do_append = 1'b1;
                                app_wild  = 1'b1;
                            end
                            else
                            begin
                                // end of signature, arm the scan
                                cmd.clr_scan = 1'b1;
                                offset_next  = '0;
                                found_next   = '0;
                                phase_next   = PH_SCAN;
                                status_next  = ST_READY;
                            end
                        end
                        else if (!dpend_eff)
                        begin
                            pend_next  = value;
                            dpend_next = 1'b1;
                        end
                        else
                        begin
                            dpend_next = 1'b0;
                            if (!hex_ok(pend_reg) || !hex_ok(value))
                            begin
                                do_reject = 1'b1;
                                rej_code  = ST_BAD_HEX;
                            end
                            else
                            begin
                                do_append = 1'b1;
                                app_byte  = hex_byte;
                            end
                        end
                    end
                end
                OP_MEMORY:
                begin
                    case (phase_reg)
                        PH_SCAN:
                        begin
                            offset_next = offset_reg + OFFSET_BITS'(1);
                            if (len_reg == '0)
                            begin
                                // empty pattern matches the first byte
                                found_next  = offset_reg;
                                phase_next  = PH_FOUND;
                                status_next = ST_MATCH;
                                off_val     = offset_reg;
                            end
                            else
                            begin
                                cmd.shift = 1'b1;
                                if (hit)
                                begin
                                    found_next  = hit_offset;
                                    phase_next  = PH_FOUND;
                                    status_next = ST_MATCH;
                                    off_val     = hit_offset;
                                end
                            end
                        end
                        PH_FOUND:
                        begin
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            status_next = ST_NO_PATTERN;
                        end
                    endcase
                end
                OP_END:
                begin
                    if (phase_reg == PH_SCAN || phase_reg == PH_FOUND)
                    begin
                        if (phase_reg == PH_FOUND)
                        begin
                            status_next = ST_MATCH;
                            off_val     = found_reg;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        cmd.clr_scan = 1'b1;
                        offset_next  = '0;
                        found_next   = '0;
                        phase_next   = PH_SCAN;
                    end
                    else
                    begin
                        status_next = ST_NO_PATTERN;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        // append one entry, the last slot is the length limit
        if (do_append)
        begin
            if (len_eff == LEN_W'(MAX_PATTERN - 1))
            begin
                do_reject = 1'b1;
                rej_code  = ST_TOO_LONG;
            end
            else
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_idx  = IDX_W'(len_eff);
                cmd.wr_wild = app_wild;
                cmd.data    = app_byte;
                len_next    = len_eff + LEN_W'(1);
            end
        end

        // error drops the pattern and waits for a nul
        if (do_reject)
        begin
            cmd.clr_pat  = 1'b1;
            cmd.clr_scan = 1'b1;
            cmd.wr_en    = 1'b0;
            len_next     = '0;
            pend_next    = '0;
            dpend_next   = 1'b0;
            offset_next  = '0;
            found_next   = '0;
            phase_next   = PH_REJECT;
            status_next  = rej_code;
        end
    end

    // offset travels at the configured width, reported as 32 bits
    assign off_ext           = {RES_OFF_W'(0), off_val};
    assign match_offset_next = off_ext[RES_OFF_W-1:0];

    // result handshake
    assign result_valid_next = fire || (result_valid_reg && !result_ready);

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COLLECT;
            len_reg          <= '0;
            pend_reg         <= '0;
            dpend_reg        <= 1'b0;
            offset_reg       <= '0;
            found_reg        <= '0;
            result_valid_reg <= 1'b0;
            status_reg       <= ST_OK;
            match_offset_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            len_reg          <= len_next;
            pend_reg         <= pend_next;
            dpend_reg        <= dpend_next;
            offset_reg       <= offset_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
            if (fire)
            begin
                status_reg       <= status_next;
                match_offset_reg <= match_offset_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign match_offset = match_offset_reg;

    // checks
    `ASSERT_RST(a_fire_gives_result, clk, rst_n, (fire |=> result_valid_reg), "accepted transaction produced no result")
    `ASSERT_IMPL(a_reject_is_empty, clk, rst_n, phase_reg == PH_REJECT, (len_reg == '0) && !dpend_reg, "rejected phase holds a partial pattern")
    `ASSERT_RST(a_found_holds, clk, rst_n, ((fire && operation == OP_MEMORY && phase_reg == PH_FOUND) |=> ($stable(found_reg) && $stable(offset_reg))), "scan moved after a match")

endmodule

### hdl/wildcard_byte_signature_search.sv
// top level: controller plus a chain of shift-and cells, one per pattern entry
// depends on wsig_pkg, wsig_ctrl, wsig_cell and assert_macros.svh
//
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      operation[1:0], value[7:0]
// result    out        result_valid / result_ready  status[2:0], match_offset[31:0]
//
// every transaction gives exactly one result transaction, registered in the cycle after acceptance
// one transaction per cycle sustained while results are taken; each memory byte shifts all cells at once
// the result register stalls input only when it is full and not being taken
// reset clears the pattern, the scan and the result register; no clearing pass
`include "assert_macros.svh"

module wildcard_byte_signature_search
    import wsig_pkg::*;
#(
    parameter int MAX_PATTERN = 128,
    parameter int OFFSET_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [DATA_W-1:0]    value,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [RES_OFF_W-1:0] match_offset
);

    // the slot that reaches the length limit is never kept
    localparam int NCELL = MAX_PATTERN - 1;

    cell_cmd_t        cmd;
    logic [NCELL-1:0] valid_vec;
    logic [NCELL-1:0] match_vec;
    logic [NCELL-1:0] hit_vec;
    logic [NCELL:0]   match_ext;
    logic [NCELL:0]   valid_ext;
    logic             hit;

    // cell zero always sees a match of the empty prefix
    assign match_ext = {match_vec, 1'b1};
    assign valid_ext = {1'b0, valid_vec};
    assign hit       = |hit_vec;

    wsig_ctrl #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .match_offset (match_offset),
        .hit          (hit),
        .cmd          (cmd)
    );

    // shift-and chain
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        wsig_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_match (match_ext[i]),
            .next_valid (valid_ext[i+1]),
            .valid      (valid_vec[i]),
            .match      (match_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    // checks
    `ASSERT_RST(a_single_hit, clk, rst_n, $onehot0(hit_vec), "more than one cell claims the pattern end")
    `ASSERT_RST(a_valid_prefix, clk, rst_n, ((valid_vec & (valid_vec + NCELL'(1))) == '0), "filled entries are not contiguous from entry zero")
    `ASSERT_IMPL(a_offset_only_on_match, clk, rst_n, result_valid && status != ST_MATCH, match_offset == '0, "offset reported without a match")

endmodule

### tb/sv/wildcard_byte_signature_search_tb.sv
// self-checking testbench for the wildcard byte signature search block
// depends on wsig_pkg and the wildcard_byte_signature_search top level
// a built-in predictor follows every transaction, results are checked in order
module wildcard_byte_signature_search_tb
    import wsig_pkg::*;
;

    localparam int SIG_DEPTH     = 128;
    localparam int RANDOM_ITEMS  = 320;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    // operation code that the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {COLLECTING, SCANNING, REJECTED, FOUND} scan_phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [RES_OFF_W-1:0] offset;
    } search_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [OP_W-1:0]      operation = OP_PATTERN;
    logic [DATA_W-1:0]    value = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [RES_OFF_W-1:0] match_offset;

    // expected results waiting for their transaction
    search_result_t pending_results[$];
    search_result_t head;
    int             errors = 0;
    int             useful_count = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             idle_on = 1'b1;

    // predictor state
    logic [DATA_W-1:0]    pat_bytes [0:SIG_DEPTH-1];
    logic [SIG_DEPTH-1:0] pat_wild;
    int                   pat_len;
    logic [DATA_W-1:0]    high_digit;
    bit                   digit_held;
    scan_phase_t          phase;
    logic [SIG_DEPTH-1:0] partial_hits;
    logic [RES_OFF_W-1:0] region_offset;
    logic [RES_OFF_W-1:0] first_hit;

    // signature currently used for stimulus
    logic [DATA_W-1:0] sig_byte [0:SIG_DEPTH+3];
    bit                sig_wild [0:SIG_DEPTH+3];
    int                sig_len;

    wildcard_byte_signature_search #(
        .MAX_PATTERN (SIG_DEPTH),
        .OFFSET_BITS (RES_OFF_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .match_offset (match_offset)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic bit nibble_of(input logic [DATA_W-1:0] c, output logic [3:0] v);
        bit ok;
        ok = 1'b1;
        v = '0;
        if (c >= "0" && c <= "9")
        begin
            v = 4'(c - "0");
        end
        else if (c >= "A" && c <= "F")
        begin
            v = 4'(c - "A" + 10);
        end
        else if (c >= "a" && c <= "f")
        begin
            v = 4'(c - "a" + 10);
        end
        else
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    task automatic clear_hits();
        partial_hits = '0;
        region_offset = '0;
        first_hit = '0;
    endtask

    task automatic clear_signature();
        pat_len = 0;
        high_digit = '0;
        digit_held = 1'b0;
        pat_wild = '0;
        clear_hits();
    endtask

    task automatic reject_signature(input logic [STATUS_W-1:0] code,
                                    output logic [STATUS_W-1:0] st);
        clear_signature();
        phase = REJECTED;
        st = code;
    endtask

    // one more entry; reaching the full depth is an error
    task automatic add_sig_entry(input bit wild, input logic [DATA_W-1:0] b,
                                 output logic [STATUS_W-1:0] st);
        st = ST_OK;
        if (pat_len >= SIG_DEPTH)
        begin
            reject_signature(ST_TOO_LONG, st);
        end
        else
        begin
            pat_wild[pat_len] = wild;
            if (!wild)
            begin
                pat_bytes[pat_len] = b;
            end
            pat_len++;
            if (pat_len >= SIG_DEPTH)
            begin
                reject_signature(ST_TOO_LONG, st);
            end
        end
    endtask

    task automatic step_search(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                               output logic [STATUS_W-1:0] st,
                               output logic [RES_OFF_W-1:0] off, output bit ignored);
        logic [3:0]           hi_v;
        logic [3:0]           lo_v;
        bit                   hi_ok;
        bit                   lo_ok;
        logic [SIG_DEPTH-1:0] hit_mask;
        logic [RES_OFF_W-1:0] cur;
        st = ST_OK;
        off = '0;
        ignored = 1'b0;
        case (op)
            OP_PATTERN:
            begin
                if (phase == REJECTED)
                begin
                    // only a terminator gets out of the rejected state
                    ignored = (val != CHAR_NUL);
                    if (val == CHAR_NUL)
                    begin
                        clear_signature();
                        phase = COLLECTING;
                    end
                end
                else
                begin
                    if (phase != COLLECTING)
                    begin
                        clear_signature();
                        phase = COLLECTING;
                    end
                    if (val == CHAR_NUL || val == CHAR_WILD || val == CHAR_SPACE)
                    begin
                        if (digit_held)
                        begin
                            reject_signature(ST_LONE_DIGIT, st);
                        end
                        else if (val == CHAR_WILD)
                        begin
                            add_sig_entry(1'b1, '0, st);
                        end
                        else if (val == CHAR_NUL)
                        begin
                            clear_hits();
                            phase = SCANNING;
                            st = ST_READY;
                        end
                    end
                    else if (!digit_held)
                    begin
                        high_digit = val;
                        digit_held = 1'b1;
                    end
                    else
                    begin
                        digit_held = 1'b0;
                        hi_ok = nibble_of(high_digit, hi_v);
                        lo_ok = nibble_of(val, lo_v);
                        if (!hi_ok || !lo_ok)
                        begin
                            reject_signature(ST_BAD_HEX, st);
                        end
                        else
                        begin
                            add_sig_entry(1'b0, {hi_v, lo_v}, st);
                        end
                    end
                end
            end
            OP_MEMORY:
            begin
                if (phase == COLLECTING || phase == REJECTED)
                begin
                    st = ST_NO_PATTERN;
                    ignored = 1'b1;
                end
                else if (phase == SCANNING)
                begin
                    cur = region_offset;
                    region_offset = region_offset + 1'b1;
                    if (pat_len == 0)
                    begin
                        first_hit = cur;
                        phase = FOUND;
                        st = ST_MATCH;
                        off = cur;
                    end
                    else
                    begin
                        // shift-and update over the live entries
                        hit_mask = '0;
                        for (int i = 0; i < pat_len; i++)
                        begin
                            hit_mask[i] = pat_wild[i] || pat_bytes[i] == val;
                        end
                        partial_hits = ((partial_hits << 1) | 1'b1) & hit_mask;
                        if (partial_hits[pat_len-1])
                        begin
                            first_hit = cur - RES_OFF_W'(pat_len - 1);
                            phase = FOUND;
                            st = ST_MATCH;
                            off = first_hit;
                        end
                    end
                end
            end
            OP_END:
            begin
                if (phase == COLLECTING || phase == REJECTED)
                begin
                    st = ST_NO_PATTERN;
                    ignored = 1'b1;
                end
                else
                begin
                    if (phase == FOUND)
                    begin
                        st = ST_MATCH;
                        off = first_hit;
                    end
                    else
                    begin
                        st = ST_NOT_FOUND;
                    end
                    clear_hits();
                    phase = SCANNING;
                end
            end
            default:
            begin
                ignored = 1'b1;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // driving and checking
    // ---------------------------------------------------------------

    // one input transaction, with an occasional gap in front of it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        logic [STATUS_W-1:0]  st;
        logic [RES_OFF_W-1:0] off;
        bit                   ignored;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation <= op;
        value <= val;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        step_search(op, val, st, off, ignored);
        pending_results.push_back('{status: st, offset: off});
        if (!ignored)
        begin
            useful_count++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(OP_PATTERN, s[i]);
        end
    endtask

    // result side stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            result_ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d offset %0d",
                         $time, status, match_offset);
                errors++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (status !== head.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, head.status, status);
                    errors++;
                end
                if (match_offset !== head.offset)
                begin
                    $display("%0t: match_offset expected %0d got %0d",
                             $time, head.offset, match_offset);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // ascii digit for one nibble, letters in random case
    function automatic logic [DATA_W-1:0] nibble_text(input logic [3:0] n);
        logic [DATA_W-1:0] c;
        if (n < 10)
        begin
            c = "0" + n;
        end
        else
        begin
            c = DATA_W'((($urandom_range(0, 1) == 1) ? "a" : "A") + n - 10);
        end
        return c;
    endfunction

    task automatic make_signature(input int n, input int wild_pct);
        sig_len = n;
        for (int i = 0; i < n; i++)
        begin
            sig_wild[i] = ($urandom_range(0, 99) < wild_pct);
            sig_byte[i] = DATA_W'($urandom_range(0, 255));
        end
    endtask

    // well-formed text for the current signature, spaces sprinkled in
    task automatic send_signature();
        for (int i = 0; i < sig_len; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(OP_PATTERN, CHAR_SPACE);
            end
            if (sig_wild[i])
            begin
                send_item(OP_PATTERN, CHAR_WILD);
            end
            else
            begin
                send_item(OP_PATTERN, nibble_text(sig_byte[i][7:4]));
                send_item(OP_PATTERN, nibble_text(sig_byte[i][3:0]));
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            send_item(OP_PATTERN, CHAR_SPACE);
        end
        send_item(OP_PATTERN, CHAR_NUL);
    endtask

    // memory region with decoys and maybe the signature planted, possibly cut
    // off by the region end
    task automatic send_region(input int n, input bit plant);
        int                at;
        logic [DATA_W-1:0] b;
        at = n;
        if (plant && n > 0)
        begin
            if (n >= sig_len && $urandom_range(0, 3) != 0)
            begin
                at = $urandom_range(0, n - sig_len);
            end
            else
            begin
                at = $urandom_range(0, n - 1);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            b = DATA_W'($urandom_range(0, 255));
            if (i >= at && i - at < sig_len)
            begin
                if (!sig_wild[i-at])
                begin
                    b = sig_byte[i-at];
                end
            end
            else if (sig_len > 0 && $urandom_range(0, 2) == 0)
            begin
                b = sig_byte[$urandom_range(0, sig_len - 1)];
            end
            send_item(OP_MEMORY, b);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_item(OP_END, DATA_W'($urandom_range(0, 255)));
        end
    endtask

    // random characters, mostly hex digits, usually terminated
    task automatic send_broken_signature();
        int                n;
        logic [DATA_W-1:0] c;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 6))
                0, 1, 2, 3: c = nibble_text(4'($urandom_range(0, 15)));
                4:          c = CHAR_WILD;
                5:          c = CHAR_SPACE;
                default:    c = DATA_W'($urandom_range(1, 255));
            endcase
            send_item(OP_PATTERN, c);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            send_item(OP_PATTERN, CHAR_NUL);
        end
    endtask

    task automatic send_noise();
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        repeat ($urandom_range(1, 6))
        begin
            op = OP_W'($urandom_range(0, 3));
            val = DATA_W'($urandom_range(0, 255));
            send_item(op, val);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // memory and end before any signature, and the unused operation
    task automatic test_no_pattern();
        send_item(OP_MEMORY, 8'h00);
        send_item(OP_END, 8'hFF);
        send_item(OP_UNUSED, 8'hFF);
    endtask

    task automatic test_parse_errors();
        // lone digit before the terminator, then restart
        send_text("A");
        send_item(OP_PATTERN, CHAR_NUL);
        send_item(OP_PATTERN, CHAR_NUL);
        // lone digit before a space
        send_text("f ");
        send_item(OP_PATTERN, CHAR_NUL);
        // lone digit before a wildcard wins over the invalid digit
        send_text("G?");
        // ignored while rejected
        send_text("z");
        send_item(OP_PATTERN, CHAR_NUL);
        // bad first digit of a pair
        send_text("g0");
        send_item(OP_PATTERN, CHAR_NUL);
    endtask

    // empty signature hits at the first byte; later bytes stay quiet
    task automatic test_empty_pattern();
        send_item(OP_PATTERN, CHAR_NUL);
        send_item(OP_MEMORY, 8'hFF);
        send_item(OP_MEMORY, 8'h00);
        send_item(OP_END, 8'h00);
    endtask

    // mixed case byte plus wildcard, dropping the old pattern
    task automatic test_match();
        send_text("fF?");
        send_item(OP_PATTERN, CHAR_NUL);
        send_item(OP_MEMORY, 8'h12);
        send_item(OP_MEMORY, 8'hFF);
        send_item(OP_MEMORY, 8'h34);
        send_item(OP_END, 8'h55);
    endtask

    // deepest legal signature, then one entry too many
    task automatic test_length_limit();
        make_signature(SIG_DEPTH - 1, 95);
        send_signature();
        send_region(SIG_DEPTH + 8, 1'b1);
        make_signature(SIG_DEPTH, 95);
        send_signature();
    endtask

    task automatic test_random_traffic();
        int n;
        useful_count = 0;
        while (useful_count < RANDOM_ITEMS)
        begin
            // last quarter runs at full rate on both sides
            if (useful_count >= RANDOM_ITEMS * 3 / 4)
            begin
                idle_on = 1'b0;
            end
            case ($urandom_range(0, 19))
                16, 17, 18:
                begin
                    send_broken_signature();
                end
                19:
                begin
                    send_noise();
                end
                default:
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16)
                                                    : $urandom_range(0, 5);
                    make_signature(n, 30);
                    send_signature();
                    repeat ($urandom_range(1, 3))
                    begin
                        send_region(n + $urandom_range(0, 20), $urandom_range(0, 3) != 0);
                    end
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // sequence and end of run
    // ---------------------------------------------------------------

    initial
    begin
        clear_signature();
        phase = COLLECTING;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_no_pattern();
        test_parse_errors();
        test_empty_pattern();
        test_match();
        test_length_limit();
        test_random_traffic();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("[wildcard_byte_signature_search] OK");
        end
        else
        begin
            $display("[wildcard_byte_signature_search] ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[wildcard_byte_signature_search] ERROR");
        $finish;
    end

endmodule

### wildcard_byte_signature_search.f
+incdir+hdl
hdl/wsig_pkg.sv
hdl/wsig_cell.sv
hdl/wsig_ctrl.sv
hdl/wildcard_byte_signature_search.sv
tb/sv/wildcard_byte_signature_search_tb.sv
